// ----- rtl/satc_pkg.sv -----
// Shared types and constants for the safety arming and trip controller.
// Holds the transaction payload structs, register indexes, reset values and
// the arming state encoding. No dependencies.
package satc_pkg;

  localparam int CNT_W   = 10;
  localparam int ALARM_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEARTBEAT_TIMEOUT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_HOLD_TICKS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAY_SETTLE_TICKS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_WAIT_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_WAIT_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ALARM_PULSE_TICKS  = 3'd5;

  // register reset values
  localparam logic [CNT_W-1:0]   RST_HEARTBEAT_TIMEOUT  = 10'd20;
  localparam logic [CNT_W-1:0]   RST_ARM_HOLD_TICKS     = 10'd200;
  localparam logic [CNT_W-1:0]   RST_RELAY_SETTLE_TICKS = 10'd200;
  localparam logic [CNT_W-1:0]   RST_BRAKE_WAIT_TICKS   = 10'd500;
  localparam logic [CNT_W-1:0]   RST_FINAL_WAIT_TICKS   = 10'd100;
  localparam logic [ALARM_W-1:0] RST_ALARM_PULSE_TICKS  = 8'd25;

  // command bytes
  localparam logic [7:0] CMD_TRIP     = 8'h45; // 'E'
  localparam logic [7:0] CMD_HB_HIGH  = 8'h2B; // '+'
  localparam logic [7:0] CMD_HB_LOW   = 8'h2D; // '-'
  localparam logic [7:0] CMD_ALARM    = 8'h41; // 'A'
  localparam logic [7:0] CMD_BRAKE_ON = 8'h42; // 'B'
  localparam logic [7:0] CMD_BRAKE_OFF = 8'h48; // 'H'

  // message codes
  localparam logic [3:0] MSG_NONE          = 4'd0;
  localparam logic [3:0] MSG_ARMED         = 4'd1;
  localparam logic [3:0] MSG_BUTTON_FAIL   = 4'd2;
  localparam logic [3:0] MSG_RELAY_ON      = 4'd3;
  localparam logic [3:0] MSG_STAGE5        = 4'd4;
  localparam logic [3:0] MSG_THR_FAIL_3    = 4'd5;
  localparam logic [3:0] MSG_THR_FAIL_5    = 4'd6;
  localparam logic [3:0] MSG_BRAKE_RELEASE = 4'd7;
  localparam logic [3:0] MSG_READY         = 4'd8;
  localparam logic [3:0] MSG_DASH_STOP     = 4'd9;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_HOLD   = 11'b000_0000_0010,
    ST_RELAY  = 11'b000_0000_0100,
    ST_SETTLE = 11'b000_0000_1000,
    ST_BRAKE  = 11'b000_0001_0000,
    ST_BWAIT  = 11'b000_0010_0000,
    ST_RELEASE = 11'b000_0100_0000,
    ST_FINAL  = 11'b000_1000_0000,
    ST_GO     = 11'b001_0000_0000,
    ST_READY  = 11'b010_0000_0000,
    ST_FAULT  = 11'b100_0000_0000
  } arm_state_t;

  typedef struct packed {
    logic       tick;
    logic       byte_valid;
    logic [7:0] rx_byte;
    logic       arm_button_level;
    logic       throttle_pressed;
    logic       dash_stop_level;
  } in_item_t;

  typedef struct packed {
    logic       trip_relay;
    logic       stop_led;
    logic       alarm_out;
    logic       brake_line;
    logic       heartbeat_led;
    logic       throttle_fault_led;
    logic       brake_enable_echo;
    logic [3:0] arm_stage;
    logic       ack_valid;
    logic [7:0] ack_byte;
    logic       tripped_now;
    logic [3:0] message;
  } out_item_t;

  // supervisor state carried from pass to pass
  typedef struct packed {
    arm_state_t         st;
    logic               hb_level;
    logic               hb_tripped;
    logic               trip_pending;
    logic               tripped;
    logic               brake_enable;
    logic [CNT_W-1:0]   hb_count;
    logic [CNT_W-1:0]   arm_count;
    logic [ALARM_W-1:0] alarm_count;
    logic               relay;
    logic               stop;
    logic               alarm;
    logic               brake;
    logic               hb_led;
    logic               thr_led;
  } sup_state_t;

endpackage

// ----- rtl/safety_arming_trip_controller.sv -----
// Safety arming and trip controller: one supervisor pass per transaction.
// Structure: input register, then result register; a result is registered from the
// held input once the result register is empty or being taken, and can then be taken.
// Throughput: one transaction per cycle, set by the single combinational pass
// between the two registers; a held result stalls the input once both are full.
// Reset (rst, synchronous): arming idle, counters clear, brake line high,
// configuration registers back to their defaults, both stages empty.
module safety_arming_trip_controller
  import satc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CNT_W-1:0]   cfg_timeout, cfg_hold, cfg_settle, cfg_brake, cfg_final;
  logic [ALARM_W-1:0] cfg_alarm;

  logic       in_q_valid;
  in_item_t   in_q;
  logic       proc;
  sup_state_t sup, sup_next;
  out_item_t  res_next;

  function automatic sup_state_t do_trip(sup_state_t s);
    sup_state_t r;
    r = s;
    r.tripped = 1'b1;
    r.relay = 1'b0;
    r.stop = 1'b1;
    r.alarm = 1'b1;
    if (s.brake_enable) r.brake = 1'b0;
    r.hb_led = s.hb_tripped;
    r.st = ST_FAULT;
    r.trip_pending = 1'b0;
    return r;
  endfunction

  function automatic sup_state_t stage_wait(sup_state_t s, logic [CNT_W-1:0] limit,
                                            arm_state_t nxt);
    sup_state_t r;
    r = s;
    if (s.arm_count > limit) r.st = nxt;
    else if (s.arm_count != CNT_MAX) r.arm_count = s.arm_count + 1'b1;
    return r;
  endfunction

  assign proc     = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_timeout <= RST_HEARTBEAT_TIMEOUT;
      cfg_hold    <= RST_ARM_HOLD_TICKS;
      cfg_settle  <= RST_RELAY_SETTLE_TICKS;
      cfg_brake   <= RST_BRAKE_WAIT_TICKS;
      cfg_final   <= RST_FINAL_WAIT_TICKS;
      cfg_alarm   <= RST_ALARM_PULSE_TICKS;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_HEARTBEAT_TIMEOUT:  cfg_timeout <= cfg_data;
        CFG_ARM_HOLD_TICKS:     cfg_hold    <= cfg_data;
        CFG_RELAY_SETTLE_TICKS: cfg_settle  <= cfg_data;
        CFG_BRAKE_WAIT_TICKS:   cfg_brake   <= cfg_data;
        CFG_FINAL_WAIT_TICKS:   cfg_final   <= cfg_data;
        CFG_ALARM_PULSE_TICKS:  cfg_alarm   <= cfg_data[ALARM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    sup_state_t s;
    logic       armed;
    logic       did_trip;
    logic       old_level;
    logic       released;
    logic [3:0] msg;
    logic [3:0] stage;

    s = sup;
    did_trip = 1'b0;
    msg = MSG_NONE;
    released = in_q.arm_button_level;

    // timer tick first
    if (in_q.tick) begin
      armed = (s.st != ST_IDLE) && (s.st != ST_FAULT);
      if (s.hb_count > cfg_timeout) begin
        if (armed) begin
          s.hb_tripped = 1'b1;
          s.trip_pending = 1'b1;
        end else begin
          s.hb_count = '0;
        end
      end else if (s.hb_count != CNT_MAX) begin
        s.hb_count = s.hb_count + 1'b1;
      end
      case (s.st)
        ST_HOLD:   s = stage_wait(s, cfg_hold, ST_RELAY);
        ST_SETTLE: s = stage_wait(s, cfg_settle, ST_BRAKE);
        ST_BWAIT:  s = stage_wait(s, cfg_brake, ST_RELEASE);
        ST_FINAL:  s = stage_wait(s, cfg_final, ST_GO);
        ST_IDLE, ST_READY: s.arm_count = '0;
        default: ;
      endcase
      if (s.alarm_count != '0) s.alarm_count = s.alarm_count - 1'b1;
    end

    if (s.trip_pending) begin
      s = do_trip(s);
      did_trip = 1'b1;
    end

    if (in_q.byte_valid) begin
      old_level = s.hb_level;
      if (in_q.rx_byte == CMD_TRIP && !s.tripped) begin
        s = do_trip(s);
        did_trip = 1'b1;
      end
      if (in_q.rx_byte == CMD_HB_HIGH) s.hb_level = 1'b1;
      if (in_q.rx_byte == CMD_HB_LOW) s.hb_level = 1'b0;
      if (in_q.rx_byte == CMD_BRAKE_ON) s.brake_enable = 1'b1;
      if (in_q.rx_byte == CMD_BRAKE_OFF) s.brake_enable = 1'b0;
      if (in_q.rx_byte == CMD_ALARM) begin
        s.alarm_count = cfg_alarm;
        s.alarm = 1'b1;
      end
      if (old_level != s.hb_level) s.hb_count = '0;
    end

    if (!s.tripped) begin
      s.hb_led = s.hb_level;
      if (s.alarm_count == '0) s.alarm = 1'b0;
    end

    armed = (s.st != ST_IDLE) && (s.st != ST_FAULT);
    if (armed && !in_q.dash_stop_level && !s.tripped) begin
      msg = MSG_DASH_STOP;
      s = do_trip(s);
      did_trip = 1'b1;
    end

    case (s.st)
      ST_IDLE: begin
        if (!released) begin
          if (s.brake_enable) s.brake = 1'b0;
          s.thr_led = 1'b0;
          s.stop = 1'b0;
          s.alarm = 1'b0;
          s.relay = 1'b0;
          s.tripped = 1'b0;
          s.hb_tripped = 1'b0;
          s.st = ST_HOLD;
          s.arm_count = '0;
          s.hb_count = '0;
          msg = MSG_ARMED;
        end
      end
      ST_HOLD: begin
        if (released) begin
          s.st = ST_FAULT;
          msg = MSG_BUTTON_FAIL;
        end
      end
      ST_RELAY: begin
        s.relay = 1'b1;
        s.st = ST_SETTLE;
        s.arm_count = '0;
        msg = MSG_RELAY_ON;
      end
      ST_SETTLE: begin
        if (released) begin
          s.st = ST_FAULT;
          msg = MSG_BUTTON_FAIL;
        end
        if (in_q.throttle_pressed) begin
          s.st = ST_FAULT;
          s.thr_led = 1'b1;
          msg = MSG_THR_FAIL_3;
        end
      end
      ST_BRAKE: begin
        s.arm_count = '0;
        s.st = ST_BWAIT;
        msg = MSG_STAGE5;
      end
      ST_BWAIT, ST_FINAL: begin
        if (in_q.throttle_pressed) begin
          s.st = ST_FAULT;
          s.thr_led = 1'b1;
          msg = MSG_THR_FAIL_5;
        end
      end
      ST_RELEASE: begin
        if (released) begin
          s.brake = 1'b1;
          s.arm_count = '0;
          s.st = ST_FINAL;
          msg = MSG_BRAKE_RELEASE;
        end
      end
      ST_GO: begin
        s.st = ST_READY;
        msg = MSG_READY;
      end
      ST_FAULT: begin
        s.relay = 1'b0;
        if (released) s.st = ST_IDLE;
      end
      default: ;
    endcase

    case (s.st)
      ST_IDLE:    stage = 4'd1;
      ST_HOLD:    stage = 4'd2;
      ST_RELAY:   stage = 4'd3;
      ST_SETTLE:  stage = 4'd4;
      ST_BRAKE:   stage = 4'd5;
      ST_BWAIT:   stage = 4'd6;
      ST_RELEASE: stage = 4'd7;
      ST_FINAL:   stage = 4'd8;
      ST_GO:      stage = 4'd9;
      ST_READY:   stage = 4'd10;
      default:    stage = 4'd0;
    endcase

    sup_next = s;
    res_next.trip_relay         = s.relay;
    res_next.stop_led           = s.stop;
    res_next.alarm_out          = s.alarm;
    res_next.brake_line         = s.brake;
    res_next.heartbeat_led      = s.hb_led;
    res_next.throttle_fault_led = s.thr_led;
    res_next.brake_enable_echo  = s.brake_enable;
    res_next.arm_stage          = stage;
    res_next.ack_valid          = in_q.byte_valid;
    res_next.ack_byte           = in_q.byte_valid ? in_q.rx_byte : 8'd0;
    res_next.tripped_now        = did_trip;
    res_next.message            = msg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      out_valid  <= 1'b0;
      sup.st           <= ST_IDLE;
      sup.hb_level     <= 1'b0;
      sup.hb_tripped   <= 1'b0;
      sup.trip_pending <= 1'b0;
      sup.tripped      <= 1'b0;
      sup.brake_enable <= 1'b1;
      sup.hb_count     <= '0;
      sup.arm_count    <= '0;
      sup.alarm_count  <= '0;
      sup.relay        <= 1'b0;
      sup.stop         <= 1'b0;
      sup.alarm        <= 1'b0;
      sup.brake        <= 1'b1;
      sup.hb_led       <= 1'b0;
      sup.thr_led      <= 1'b0;
    end else begin
      if (in_valid && !in_stall) in_q_valid <= 1'b1;
      else if (proc) in_q_valid <= 1'b0;
      if (proc) begin
        out_valid <= 1'b1;
        sup <= sup_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_q <= in_data;
    if (proc) out_data <= res_next;
  end

endmodule
